/* rtl/core/byte_stuffing_framer_top_defines.svh */
// assertion macros for the byte stuffing framer checker
// needs clk and rst_n in the scope where a macro is used
`ifndef BYTE_STUFFING_FRAMER_TOP_DEFINES_SVH
`define BYTE_STUFFING_FRAMER_TOP_DEFINES_SVH

// same-cycle implication, disabled in reset
`define BSF_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled in reset
`define BSF_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/core/bsf_pkg.sv */
// types, codes and reset values shared by the byte stuffing framer
// no dependencies
package bsf_pkg;

    localparam int unsigned NumRegs = 3;

    typedef enum logic [1:0] {
        ACT_SEND_START = 2'd0,
        ACT_SEND_END   = 2'd1,
        ACT_SEND_DATA  = 2'd2,
        ACT_RECEIVE    = 2'd3
    } bsf_action_t;

    typedef enum logic [2:0] {
        KIND_LINE  = 3'd0,
        KIND_START = 3'd1,
        KIND_END   = 3'd2,
        KIND_DATA  = 3'd3,
        KIND_ERROR = 3'd4
    } bsf_kind_t;

    typedef enum logic [1:0] {
        PH_WAIT = 2'd0,
        PH_DATA = 2'd1,
        PH_ESC  = 2'd2
    } bsf_phase_t;

    typedef enum logic [1:0] {
        REG_START_CHAR  = 2'd0,
        REG_END_CHAR    = 2'd1,
        REG_ESCAPE_CHAR = 2'd2
    } bsf_reg_t;

    localparam logic [7:0] StartCharReset  = 8'h02;
    localparam logic [7:0] EndCharReset    = 8'h03;
    localparam logic [7:0] EscapeCharReset = 8'h10;

    typedef struct packed {
        logic [7:0] start_char;
        logic [7:0] end_char;
        logic [7:0] escape_char;
    } bsf_cfg_t;

    typedef struct packed {
        logic [2:0] kind;
        logic [7:0] out_byte;
        logic       last;
    } bsf_result_t;

    // results of one request handed to the output buffer
    typedef struct packed {
        logic [1:0]  count;
        bsf_result_t first;
        bsf_result_t second;
    } bsf_push_t;

endpackage

/* rtl/core/bsf_in_if.sv */
// request channel of the byte stuffing framer
// depends on nothing
interface bsf_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] action;
    logic [7:0] data_byte;

    modport source (output valid, output action, output data_byte, input ready);
    modport sink (input valid, input action, input data_byte, output ready);
endinterface

/* rtl/core/bsf_out_if.sv */
// result channel of the byte stuffing framer
// depends on nothing
interface bsf_out_if;
    logic       valid;
    logic       ready;
    logic [2:0] kind;
    logic [7:0] out_byte;
    logic       last;

    modport source (output valid, output kind, output out_byte, output last, input ready);
    modport sink (input valid, input kind, input out_byte, input last, output ready);
endinterface

/* rtl/core/bsf_cfg.sv */
// start, end and escape character registers with plain write port
// depends on bsf_pkg
module bsf_cfg
    import bsf_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_we,
    input  logic [1:0] cfg_index,
    input  logic [7:0] cfg_wdata,
    output bsf_cfg_t   cfg
);

    bsf_cfg_t cfg_reg;
    bsf_cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                REG_START_CHAR:  cfg_next.start_char  = cfg_wdata;
                REG_END_CHAR:    cfg_next.end_char    = cfg_wdata;
                REG_ESCAPE_CHAR: cfg_next.escape_char = cfg_wdata;
                default:         cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.start_char  <= StartCharReset;
            cfg_reg.end_char    <= EndCharReset;
            cfg_reg.escape_char <= EscapeCharReset;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

/* rtl/core/bsf_core.sv */
// input register, transmit stuffing and receive deframing decode
// depends on bsf_pkg and bsf_in_if
module bsf_core
    import bsf_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    bsf_in_if.sink    in_ch,
    input  bsf_cfg_t  cfg,
    input  logic [1:0] room,
    output bsf_push_t push
);

    logic        valid_reg;
    logic        valid_next;
    bsf_action_t action_reg;
    logic [7:0]  byte_reg;
    bsf_phase_t  phase_reg;
    bsf_phase_t  phase_next;
    bsf_phase_t  phase_dec;
    bsf_push_t   dec;
    logic        accept;
    logic        advance;
    logic        is_start;
    logic        is_end;
    logic        is_esc;

    assign is_start = (byte_reg == cfg.start_char);
    assign is_end   = (byte_reg == cfg.end_char);
    assign is_esc   = (byte_reg == cfg.escape_char);

    always_comb
    begin
        dec        = '0;
        phase_dec  = phase_reg;
        case (action_reg)
            ACT_SEND_START:
            begin
                dec.count = 2'd1;
                dec.first = '{kind: KIND_LINE, out_byte: cfg.start_char, last: 1'b1};
            end
            ACT_SEND_END:
            begin
                dec.count = 2'd1;
                dec.first = '{kind: KIND_LINE, out_byte: cfg.end_char, last: 1'b1};
            end
            ACT_SEND_DATA:
            begin
                if (is_start || is_end || is_esc)
                begin
                    dec.count  = 2'd2;
                    dec.first  = '{kind: KIND_LINE, out_byte: cfg.escape_char, last: 1'b0};
                    dec.second = '{kind: KIND_LINE, out_byte: byte_reg, last: 1'b1};
                end
                else
                begin
                    dec.count = 2'd1;
                    dec.first = '{kind: KIND_LINE, out_byte: byte_reg, last: 1'b1};
                end
            end
            default:
            begin
                case (phase_reg)
                    PH_DATA:
                    begin
                        if (is_start)
                        begin
                            dec.count = 2'd1;
                            dec.first = '{kind: KIND_START, out_byte: 8'd0, last: 1'b1};
                        end
                        else if (is_end)
                        begin
                            phase_dec = PH_WAIT;
                            dec.count = 2'd1;
                            dec.first = '{kind: KIND_END, out_byte: 8'd0, last: 1'b1};
                        end
                        else if (is_esc)
                        begin
                            phase_dec = PH_ESC;
                        end
                        else
                        begin
                            dec.count = 2'd1;
                            dec.first = '{kind: KIND_DATA, out_byte: byte_reg, last: 1'b1};
                        end
                    end
                    PH_ESC:
                    begin
                        dec.count = 2'd1;
                        if (is_start || is_end || is_esc)
                        begin
                            phase_dec = PH_DATA;
                            dec.first = '{kind: KIND_DATA, out_byte: byte_reg, last: 1'b1};
                        end
                        else
                        begin
                            phase_dec = PH_WAIT;
                            dec.first = '{kind: KIND_ERROR, out_byte: 8'd0, last: 1'b1};
                        end
                    end
                    default:
                    begin
                        // waiting, junk before start is dropped
                        if (is_start)
                        begin
                            phase_dec = PH_DATA;
                            dec.count = 2'd1;
                            dec.first = '{kind: KIND_START, out_byte: 8'd0, last: 1'b1};
                        end
                        else
                        begin
                            phase_dec = PH_WAIT;
                        end
                    end
                endcase
            end
        endcase
    end

    assign advance      = valid_reg && (dec.count <= room);
    assign in_ch.ready  = !valid_reg || advance;
    assign accept       = in_ch.valid && in_ch.ready;
    assign valid_next   = accept || (valid_reg && !advance);
    assign phase_next   = advance ? phase_dec : phase_reg;

    always_comb
    begin
        push = dec;
        if (!advance)
        begin
            push.count = 2'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            phase_reg <= PH_WAIT;
        end
        else
        begin
            valid_reg <= valid_next;
            phase_reg <= phase_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            action_reg <= bsf_action_t'(in_ch.action);
            byte_reg   <= in_ch.data_byte;
        end
    end

endmodule

/* rtl/core/bsf_outbuf.sv */
// two-entry result buffer, takes up to two results a cycle as room allows, gives one when ready
// depends on bsf_pkg and bsf_out_if
module bsf_outbuf
    import bsf_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  bsf_push_t  push,
    output logic [1:0] room,
    bsf_out_if.source  out_ch
);

    bsf_result_t slot_reg [2];
    logic [1:0]  count_reg;
    logic [1:0]  count_next;
    logic        rd_ptr_reg;
    logic        rd_ptr_next;
    logic        wr_ptr;
    logic        pop;
    bsf_result_t head;

    assign pop         = out_ch.valid && out_ch.ready;
    assign room        = 2'd2 - count_reg + {1'b0, pop};
    assign wr_ptr      = rd_ptr_reg ^ count_reg[0];
    assign count_next  = count_reg - {1'b0, pop} + push.count;
    assign rd_ptr_next = rd_ptr_reg ^ pop;

    assign head            = slot_reg[rd_ptr_reg];
    assign out_ch.valid    = (count_reg != 2'd0);
    assign out_ch.kind     = head.kind;
    assign out_ch.out_byte = head.out_byte;
    assign out_ch.last     = head.last;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg  <= 2'd0;
            rd_ptr_reg <= 1'b0;
        end
        else
        begin
            count_reg  <= count_next;
            rd_ptr_reg <= rd_ptr_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push.count != 2'd0)
        begin
            slot_reg[wr_ptr] <= push.first;
        end
        if (push.count == 2'd2)
        begin
            slot_reg[~wr_ptr] <= push.second;
        end
    end

endmodule

/* rtl/core/byte_stuffing_framer_top.sv */
// Byte stuffing framer and deframer. Each request on in_ch is either a transmit
// action (send start, send end, send data byte) or a byte received from the line.
// Transmit data equal to the start, end or escape character goes out as the escape
// character and then the byte. Received bytes are deframed by a three-phase machine
// into frame started, frame ended, payload byte and escape error results; junk
// before a start and the escape itself give no result. A request enters a one-stage
// input register and is decoded into a two-entry result buffer, so one request per
// cycle is taken while the buffer has room; the result port gives one result per
// cycle when out_ch is ready, so a stuffed byte can stall the input. Characters
// reset to 0x02, 0x03 and 0x10 and are written by cfg_we/cfg_index/cfg_wdata; the
// user must write only while the block is idle; the block does not enforce it.
// depends on bsf_pkg, bsf_in_if, bsf_out_if, bsf_cfg, bsf_core, bsf_outbuf
module byte_stuffing_framer_top
    import bsf_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    bsf_in_if.sink     in_ch,
    bsf_out_if.source  out_ch,
    input  logic       cfg_we,
    input  logic [1:0] cfg_index,
    input  logic [7:0] cfg_wdata
);

    bsf_cfg_t  cfg;
    bsf_push_t push;
    logic [1:0] room;

    bsf_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    bsf_core u_core (
        .clk   (clk),
        .rst_n (rst_n),
        .in_ch (in_ch),
        .cfg   (cfg),
        .room  (room),
        .push  (push)
    );

    bsf_outbuf u_outbuf (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (push),
        .room   (room),
        .out_ch (out_ch)
    );

endmodule

/* rtl/core/bsf_checker.sv */
// port-level checks on the framer result channel, bound to the top level
// depends on bsf_pkg and byte_stuffing_framer_top_defines.svh
`include "byte_stuffing_framer_top_defines.svh"

module bsf_checker
    import bsf_pkg::*;
(
    input logic       clk,
    input logic       rst_n,
    input logic       out_valid,
    input logic       out_ready,
    input logic [2:0] out_kind,
    input logic [7:0] out_byte,
    input logic       out_last
);

    logic stalled;
    logic no_byte_kind;
    logic rx_kind;

    assign stalled      = out_valid && !out_ready;
    assign no_byte_kind = (out_kind == KIND_START) || (out_kind == KIND_END)
                       || (out_kind == KIND_ERROR);
    assign rx_kind      = no_byte_kind || (out_kind == KIND_DATA);

    `BSF_ASSERT_NXT(a_out_hold, stalled, out_valid, "result dropped while stalled")
    `BSF_ASSERT_NXT(a_out_stable, stalled, $stable({out_kind, out_byte, out_last}), "stalled result changed")
    `BSF_ASSERT_IMP(a_kind_range, out_valid, out_kind <= KIND_ERROR, "result kind out of range")
    `BSF_ASSERT_IMP(a_zero_byte, out_valid && no_byte_kind, out_byte == 8'd0, "status result with byte")
    `BSF_ASSERT_IMP(a_rx_last, out_valid && rx_kind, out_last, "receive result not last")

endmodule

bind byte_stuffing_framer_top bsf_checker u_bsf_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_kind  (out_ch.kind),
    .out_byte  (out_ch.out_byte),
    .out_last  (out_ch.last)
);
